// File: sv/gds_pkg.sv
package gds_pkg;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;
  localparam int VTX_W       = 8;
  localparam int VCOUNT_W    = 9;
  localparam int DEG_OUT_W   = 16;
  localparam int EQ_W        = 9;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam logic CFG_IDX_VERTEX_COUNT = 1'b0;
  localparam logic [VCOUNT_W-1:0] VERTEX_COUNT_RESET = 9'd256;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_RUN,
    ST_SCAN,
    ST_FIN,
    ST_DONE
  } gds_state_t;

  typedef struct packed {
    logic             is_report;
    logic [VTX_W-1:0] src;
    logic [VTX_W-1:0] dst;
  } gds_entry_t;

  typedef struct packed {
    logic       valid;
    gds_entry_t entry;
  } gds_q_head_t;

endpackage

// File: sv/gds_front.sv
module gds_front #(
  parameter int NW = 9
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [NW-1:0]                   n_act,
  input  logic                            init_busy,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [gds_pkg::IN_TDATA_W-1:0]  in_tdata,   // src_vertex, dst_vertex
  input  logic                            in_tuser,   // req_type
  input  logic                            q_pop,
  output gds_pkg::gds_q_head_t            q_head
);

  gds_pkg::gds_entry_t              mem_r [gds_pkg::QUEUE_DEPTH];
  logic [gds_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [gds_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [gds_pkg::QCNT_W-1:0]       cnt_r;
  logic [gds_pkg::QCNT_W-1:0]       cnt_nxt;
  logic [gds_pkg::VTX_W-1:0]        src;
  logic [gds_pkg::VTX_W-1:0]        dst;
  logic                             accept;
  logic                             in_range;
  logic                             push;

  assign src       = in_tdata[7:0];
  assign dst       = in_tdata[15:8];
  assign in_tready = !init_busy && (cnt_r != gds_pkg::QCNT_W'(gds_pkg::QUEUE_DEPTH));
  assign accept    = in_tvalid && in_tready;
  // edges naming a vertex beyond the active count are dropped here
  assign in_range  = (NW'(src) < n_act) && (NW'(dst) < n_act);
  assign push      = accept && (in_tuser || in_range);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{is_report: in_tuser, src: src, dst: dst};
    end
  end

  assign q_head.valid = (cnt_r != '0);
  assign q_head.entry = mem_r[rd_ptr_r];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= gds_pkg::QCNT_W'(gds_pkg::QUEUE_DEPTH))
    else $error("queue count overflow");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> cnt_r != '0)
    else $error("queue empty after push");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != '0)
    else $error("pop from empty queue");

endmodule

// File: sv/gds_back.sv
module gds_back #(
  parameter int MAX_VERTICES = 256,
  parameter int DEGREE_BITS  = 16,
  parameter int AW           = 8,
  parameter int NW           = 9
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [NW-1:0]                    n_act,
  input  gds_pkg::gds_q_head_t             q_head,
  output logic                             q_pop,
  output logic                             init_busy,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [gds_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_VERTICES - 1);

  gds_pkg::gds_state_t      st_r, st_nxt;

  logic [DEGREE_BITS-1:0]   in_mem  [MAX_VERTICES];
  logic [DEGREE_BITS-1:0]   out_mem [MAX_VERTICES];
  logic [DEGREE_BITS-1:0]   in_rd_r, out_rd_r;

  logic [AW-1:0]            idx_r;
  logic                     s1_vld_r;
  logic [AW-1:0]            s1_src_r, s1_dst_r;
  logic                     sc_vld_r, sc_in_r;
  logic [AW-1:0]            sc_idx_r;

  logic                     in_wb_vld_r, out_wb_vld_r;
  logic [AW-1:0]            in_wb_addr_r, out_wb_addr_r;
  logic [DEGREE_BITS-1:0]   in_wb_data_r, out_wb_data_r;

  logic [DEGREE_BITS-1:0]   best_d_r;
  logic [AW-1:0]            best_v_r;
  logic [gds_pkg::EQ_W-1:0] eq_r;

  logic                     out_tvalid_r;
  logic [gds_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  logic                     sweep, start_scan, edge_go;
  logic [NW-1:0]            head_src_ext, head_dst_ext, idx_ext, best_v_ext;
  logic [AW-1:0]            head_src, head_dst;
  logic [AW-1:0]            in_ra, out_ra, in_wa, out_wa;
  logic                     we;
  logic [DEGREE_BITS-1:0]   in_cur, out_cur, in_inc, out_inc, in_wd, out_wd;
  logic [gds_pkg::DEG_OUT_W-1:0] deg_sat;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      gds_pkg::ST_INIT: if (idx_r == LAST_IDX) st_nxt = gds_pkg::ST_RUN;
      gds_pkg::ST_RUN:  if (start_scan) st_nxt = gds_pkg::ST_SCAN;
      gds_pkg::ST_SCAN: if (idx_r == LAST_IDX) st_nxt = gds_pkg::ST_FIN;
      gds_pkg::ST_FIN:  st_nxt = gds_pkg::ST_DONE;
      gds_pkg::ST_DONE: st_nxt = gds_pkg::ST_RUN;
      default:          st_nxt = gds_pkg::ST_INIT;
    endcase
  end

  // state outputs
  always_comb begin
    sweep      = 1'b0;
    start_scan = 1'b0;
    edge_go    = 1'b0;
    q_pop      = 1'b0;
    case (st_r)
      gds_pkg::ST_INIT: sweep = 1'b1;
      gds_pkg::ST_RUN: begin
        if (q_head.valid) begin
          if (!q_head.entry.is_report) begin
            edge_go = 1'b1;
            q_pop   = 1'b1;
          end else if (!s1_vld_r && !out_tvalid_r) begin
            start_scan = 1'b1;
            q_pop      = 1'b1;
          end
        end
      end
      gds_pkg::ST_SCAN: sweep = 1'b1;
      gds_pkg::ST_FIN:  sweep = 1'b0;
      gds_pkg::ST_DONE: sweep = 1'b0;
      default:          sweep = 1'b0;
    endcase
  end

  assign init_busy    = (st_r == gds_pkg::ST_INIT);
  assign head_src_ext = NW'(q_head.entry.src);
  assign head_dst_ext = NW'(q_head.entry.dst);
  assign head_src     = head_src_ext[AW-1:0];
  assign head_dst     = head_dst_ext[AW-1:0];
  assign idx_ext      = NW'(idx_r);

  // read-modify-write with one-deep forwarding of the previous write
  assign in_cur  = (in_wb_vld_r && in_wb_addr_r == s1_dst_r) ? in_wb_data_r : in_rd_r;
  assign out_cur = (out_wb_vld_r && out_wb_addr_r == s1_src_r) ? out_wb_data_r : out_rd_r;
  assign in_inc  = (&in_cur) ? in_cur : in_cur + 1'b1;
  assign out_inc = (&out_cur) ? out_cur : out_cur + 1'b1;

  assign in_ra  = sweep ? idx_r : head_dst;
  assign out_ra = sweep ? idx_r : head_src;
  assign we     = sweep || s1_vld_r;
  assign in_wa  = sweep ? idx_r : s1_dst_r;
  assign out_wa = sweep ? idx_r : s1_src_r;
  assign in_wd  = sweep ? '0 : in_inc;
  assign out_wd = sweep ? '0 : out_inc;

  always_ff @(posedge clk) begin
    if (we) begin
      in_mem[in_wa]   <= in_wd;
      out_mem[out_wa] <= out_wd;
    end
    in_rd_r  <= in_mem[in_ra];
    out_rd_r <= out_mem[out_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= gds_pkg::ST_INIT;
      idx_r        <= '0;
      s1_vld_r     <= 1'b0;
      sc_vld_r     <= 1'b0;
      in_wb_vld_r  <= 1'b0;
      out_wb_vld_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      s1_vld_r     <= edge_go;
      sc_vld_r     <= (st_r == gds_pkg::ST_SCAN);
      in_wb_vld_r  <= we;
      out_wb_vld_r <= we;
      if (sweep) begin
        idx_r <= (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
      end
      if (st_r == gds_pkg::ST_DONE) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_src_r      <= head_src;
    s1_dst_r      <= head_dst;
    sc_in_r       <= (idx_ext < n_act);
    sc_idx_r      <= idx_r;
    in_wb_addr_r  <= in_wa;
    in_wb_data_r  <= in_wd;
    out_wb_addr_r <= out_wa;
    out_wb_data_r <= out_wd;
    if (start_scan) begin
      best_d_r <= '0;
      best_v_r <= '0;
      eq_r     <= '0;
    end else if (sc_vld_r && sc_in_r) begin
      if (in_rd_r > best_d_r) begin
        best_d_r <= in_rd_r;
        best_v_r <= sc_idx_r;
      end
      if (in_rd_r == out_rd_r && !(&eq_r)) begin
        eq_r <= eq_r + 1'b1;
      end
    end
    if (st_r == gds_pkg::ST_DONE) begin
      out_tdata_r <= {7'd0, eq_r, deg_sat, best_v_ext[7:0]};
    end
  end

  generate
    if (DEGREE_BITS > gds_pkg::DEG_OUT_W) begin : g_wide
      assign deg_sat = (|best_d_r[DEGREE_BITS-1:gds_pkg::DEG_OUT_W]) ? '1
                       : best_d_r[gds_pkg::DEG_OUT_W-1:0];
    end else begin : g_narrow
      assign deg_sat = gds_pkg::DEG_OUT_W'(best_d_r);
    end
  endgenerate

  assign best_v_ext = NW'(best_v_r);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_scan_no_edge: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == gds_pkg::ST_SCAN |-> !s1_vld_r)
    else $error("edge update in flight during scan");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(st_r == gds_pkg::ST_DONE))
    else $error("result raised outside report completion");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.valid)
    else $error("pop without queue entry");

  a_scan_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    start_scan |-> !out_tvalid_r)
    else $error("scan started with result pending");

endmodule

// File: sv/graph_degree_statistics.sv
// edge transfer: one per cycle sustained while in_tready is high; counters are written from the s1 registers
// report transfer: at the queue head it waits for any edge update still in flight and any unread result,
//   then the scan that clears one vertex a cycle runs, and out_tvalid rises after ST_FIN and ST_DONE
// after reset a clearing pass over all MAX_VERTICES vertices holds in_tready low
// reset (rst_n, synchronous, active low) sets vertex_count to 256 and empties the queue
module graph_degree_statistics #(
  parameter int MAX_VERTICES = 256,
  parameter int DEGREE_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [gds_pkg::IN_TDATA_W-1:0]    in_tdata,   // src_vertex, dst_vertex
  input  logic                              in_tuser,   // req_type
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [gds_pkg::OUT_TDATA_W-1:0]   out_tdata,  // max_in_vertex, max_in_degree, equal_count
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [gds_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [gds_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [gds_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int MW  = $clog2(MAX_VERTICES + 1);
  localparam int NW  = (MW > gds_pkg::VCOUNT_W) ? MW : gds_pkg::VCOUNT_W;

  logic [gds_pkg::VCOUNT_W-1:0] vc_r;
  logic [NW-1:0]                vc_ext;
  logic [NW-1:0]                n_act;
  logic                         cfg_wr;
  logic                         q_pop;
  logic                         init_busy;
  gds_pkg::gds_q_head_t         q_head;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= gds_pkg::VERTEX_COUNT_RESET;
    end else if (cfg_wr && cfg_paddr[2] == gds_pkg::CFG_IDX_VERTEX_COUNT) begin
      vc_r <= cfg_pwdata[gds_pkg::VCOUNT_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == gds_pkg::CFG_IDX_VERTEX_COUNT)
                      ? gds_pkg::CFG_DATA_W'(vc_r) : '0;

  assign vc_ext = NW'(vc_r);
  assign n_act  = (vc_ext > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : vc_ext;

  gds_front #(
    .NW (NW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .n_act     (n_act),
    .init_busy (init_busy),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_pop     (q_pop),
    .q_head    (q_head)
  );

  gds_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .DEGREE_BITS  (DEGREE_BITS),
    .AW           (AW),
    .NW           (NW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .n_act      (n_act),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .init_busy  (init_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
